### hw/rtl/bfmu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmu_pkg
// Shared widths, mode codes and stage control types of the bitfield move unit.
// ----------------------------------------------------------------------------
package bfmu_pkg;

	localparam int REG_WIDTH = 64;
	localparam int DATA_W    = 64;
	localparam int SH_W      = $clog2(REG_WIDTH);
	localparam int CMP_W     = 8;
	localparam int MODE_W    = 4;
	localparam int FA_W      = 6;
	localparam int FB_W      = 7;
	localparam int EB_W      = 3;

	localparam logic [DATA_W-1:0] MASK_WIDE   = DATA_W'({REG_WIDTH{1'b1}});
	localparam logic [DATA_W-1:0] MASK_NARROW = DATA_W'({32{1'b1}});

	typedef enum logic [MODE_W-1:0] {
		MODE_UBFM  = 4'd0,
		MODE_SBFM  = 4'd1,
		MODE_UBFX  = 4'd2,
		MODE_SBFX  = 4'd3,
		MODE_UBFIZ = 4'd4,
		MODE_SBFIZ = 4'd5,
		MODE_LSL   = 4'd6,
		MODE_LSR   = 4'd7,
		MODE_ASR   = 4'd8,
		MODE_UXT   = 4'd9,
		MODE_SXT   = 4'd10
	} mode_t;

	// raw move operands after alias decode
	typedef struct packed {
		logic [SH_W-1:0] rot;
		logic [SH_W-1:0] top;
		logic            sgn;
		logic            zero;
		logic            wide;
	} bfmu_op_t;

	// field placement after rotation
	typedef struct packed {
		logic [SH_W-1:0] top_idx;
		logic [SH_W-1:0] bot_idx;
		logic            sgn;
		logic            zero;
		logic            wide;
	} bfmu_place_t;

endpackage

### hw/rtl/bfmu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmu_in_if
// Operand channel of the bitfield move unit: valid, ready and operand fields.
// ----------------------------------------------------------------------------
interface bfmu_in_if import bfmu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic              wide;
	logic [DATA_W-1:0] src_value;
	logic [FA_W-1:0]   field_a;
	logic [FB_W-1:0]   field_b;
	logic [EB_W-1:0]   ext_bytes;

	modport source (
		output valid, mode, wide, src_value, field_a, field_b, ext_bytes,
		input  ready
	);
	modport sink (
		input  valid, mode, wide, src_value, field_a, field_b, ext_bytes,
		output ready
	);
endinterface

### hw/rtl/bfmu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmu_out_if
// Result channel of the bitfield move unit: valid, ready and result value.
// ----------------------------------------------------------------------------
interface bfmu_out_if import bfmu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] result;

	modport source (
		output valid, result,
		input  ready
	);
	modport sink (
		input  valid, result,
		output ready
	);
endinterface

### hw/rtl/bfmu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmu_decode
// Reduces every form and alias to a raw move: rotate amount, top bit, sign.
// ----------------------------------------------------------------------------
module bfmu_decode import bfmu_pkg::*; (
	input  logic [MODE_W-1:0] mode,
	input  logic              wide,
	input  logic [FA_W-1:0]   field_a,
	input  logic [FB_W-1:0]   field_b,
	input  logic [EB_W-1:0]   ext_bytes,
	output bfmu_op_t          op
);
	logic [CMP_W-1:0] reg_w;
	logic [CMP_W-1:0] a_in;
	logic [CMP_W-1:0] a_mod;
	logic [CMP_W-1:0] b_in;
	logic [CMP_W-1:0] s_raw;
	logic [CMP_W-1:0] room;
	logic [CMP_W-1:0] width;
	logic [CMP_W-1:0] neg_a;
	logic [CMP_W-1:0] ebits;
	logic [CMP_W-1:0] ebits_sel;
	logic [CMP_W-1:0] r;
	logic [CMP_W-1:0] s;

	always_comb begin
		reg_w = wide ? CMP_W'(REG_WIDTH) : CMP_W'(32);
		a_in  = CMP_W'(field_a);
		a_mod = (a_in >= reg_w) ? a_in - reg_w : a_in;
		b_in  = CMP_W'(field_b);
		s_raw = (b_in >= reg_w) ? reg_w - CMP_W'(1) : b_in;
		// clamp the field so it ends inside the register
		room  = reg_w - a_mod;
		width = (b_in > room) ? room : b_in;
		neg_a = (a_mod == '0) ? '0 : reg_w - a_mod;

		case (ext_bytes)
			EB_W'(1): ebits_sel = CMP_W'(8);
			EB_W'(2): ebits_sel = CMP_W'(16);
			default:  ebits_sel = CMP_W'(32);
		endcase
		ebits = (ebits_sel > reg_w) ? reg_w : ebits_sel;

		r       = '0;
		s       = '0;
		op.sgn  = 1'b0;
		op.zero = 1'b0;
		case (mode_t'(mode))
			MODE_UBFM: begin
				r = a_mod;
				s = s_raw;
			end
			MODE_SBFM: begin
				r      = a_mod;
				s      = s_raw;
				op.sgn = 1'b1;
			end
			MODE_UBFX, MODE_SBFX: begin
				r       = a_mod;
				s       = a_mod + width - CMP_W'(1);
				op.sgn  = (mode_t'(mode) == MODE_SBFX);
				op.zero = (width == '0);
			end
			MODE_UBFIZ, MODE_SBFIZ: begin
				r       = neg_a;
				s       = width - CMP_W'(1);
				op.sgn  = (mode_t'(mode) == MODE_SBFIZ);
				op.zero = (width == '0);
			end
			MODE_LSL: begin
				r = neg_a;
				s = reg_w - CMP_W'(1) - a_mod;
			end
			MODE_LSR: begin
				r = a_mod;
				s = reg_w - CMP_W'(1);
			end
			MODE_ASR: begin
				r      = a_mod;
				s      = reg_w - CMP_W'(1);
				op.sgn = 1'b1;
			end
			MODE_UXT: begin
				s = ebits - CMP_W'(1);
			end
			MODE_SXT: begin
				s      = ebits - CMP_W'(1);
				op.sgn = 1'b1;
			end
			default: begin
				op.zero = 1'b1;
			end
		endcase

		op.rot  = r[SH_W-1:0];
		op.top  = s[SH_W-1:0];
		op.wide = wide;
	end
endmodule

### hw/rtl/bfmu_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmu_merge
// Masks the rotated source to the placed field and fills the sign above it.
// ----------------------------------------------------------------------------
module bfmu_merge import bfmu_pkg::*; (
	input  logic [DATA_W-1:0] rot_val,
	input  bfmu_place_t       place,
	output logic [DATA_W-1:0] result
);
	logic [DATA_W-1:0] mask_top;
	logic [DATA_W-1:0] mask_bot;
	logic [DATA_W-1:0] fill;
	logic [DATA_W-1:0] res_raw;
	logic              sign_bit;

	always_comb begin
		// low mask through the top bit, and low mask below the bottom bit
		mask_top = ~(({DATA_W{1'b1}} << place.top_idx) << 1);
		mask_bot = ~({DATA_W{1'b1}} << place.bot_idx);
		sign_bit = rot_val[place.top_idx];
		fill     = (place.sgn && sign_bit) ? ~mask_top : '0;
		res_raw  = (rot_val & mask_top & ~mask_bot) | fill;
		res_raw  = res_raw & (place.wide ? MASK_WIDE : MASK_NARROW);
		result   = place.zero ? '0 : res_raw;
	end
endmodule

### hw/rtl/bitfield_move_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitfield_move_unit
// Unsigned and signed bitfield moves with their extract, insert, shift and
// extend aliases; one operand set in, one result out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       payload
//  op       in   valid / ready   mode, wide, src_value, field_a, field_b, ext_bytes
//  res      out  valid / ready   result
//
//  three register stages: decode, rotate, mask and sign fill
//  an op passes the decode, rotate and mask stage registers in order; one op per cycle while res ready stays high
//  each stage advances on its own, so bubbles close up behind a stalled result
//  res ready low holds the last stage; earlier stages keep filling until full
//  arst_n clears the stage valid bits only; no other state
// ----------------------------------------------------------------------------
module bitfield_move_unit import bfmu_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	bfmu_in_if.sink    op,
	bfmu_out_if.source res
);
	// stage enables, back to front
	logic en_s1;
	logic en_s2;
	logic en_s3;

	logic v_s1;
	logic v_s2;
	logic v_s3;

	// stage 1: decoded operands and masked source
	bfmu_op_t          dec_op;
	bfmu_op_t          op_s1;
	logic [DATA_W-1:0] src_s1;

	// stage 2: rotated source and field placement
	logic [2*DATA_W-1:0] dup;
	logic [DATA_W-1:0]   rot_val;
	logic [CMP_W-1:0]    reg_w;
	logic [CMP_W-1:0]    r_ext;
	logic [CMP_W-1:0]    s_ext;
	logic [CMP_W-1:0]    top_ext;
	logic [CMP_W-1:0]    bot_ext;
	bfmu_place_t         place;
	logic [DATA_W-1:0]   rot_s2;
	bfmu_place_t         place_s2;

	// stage 3: final value
	logic [DATA_W-1:0] merged;
	logic [DATA_W-1:0] res_s3;

	assign en_s3    = !v_s3 || res.ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign op.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= op.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// alias forms fold into one raw move
	bfmu_decode u_decode (
		.mode      (op.mode),
		.wide      (op.wide),
		.field_a   (op.field_a),
		.field_b   (op.field_b),
		.ext_bytes (op.ext_bytes),
		.op        (dec_op)
	);

	always_ff @(posedge clk) begin
		if (en_s1 && op.valid) begin
			op_s1  <= dec_op;
			src_s1 <= op.src_value & (op.wide ? MASK_WIDE : MASK_NARROW);
		end
	end

	// rotate right within the register width; field top sits at (s - r) mod width
	always_comb begin
		reg_w   = op_s1.wide ? CMP_W'(REG_WIDTH) : CMP_W'(32);
		dup     = op_s1.wide ? ((2*DATA_W)'(src_s1) << REG_WIDTH)
		                     : ((2*DATA_W)'(src_s1) << 32);
		dup     = dup | (2*DATA_W)'(src_s1);
		rot_val = DATA_W'(dup >> op_s1.rot);
		r_ext   = CMP_W'(op_s1.rot);
		s_ext   = CMP_W'(op_s1.top);
		if (s_ext >= r_ext) begin
			// field taken from the middle and dropped to bit 0
			top_ext = s_ext - r_ext;
			bot_ext = '0;
		end else begin
			// low field placed up at width - r
			top_ext = reg_w - r_ext + s_ext;
			bot_ext = reg_w - r_ext;
		end
		place.top_idx = top_ext[SH_W-1:0];
		place.bot_idx = bot_ext[SH_W-1:0];
		place.sgn     = op_s1.sgn;
		place.zero    = op_s1.zero;
		place.wide    = op_s1.wide;
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			rot_s2   <= rot_val;
			place_s2 <= place;
		end
	end

	// field mask, sign fill and register width trim
	bfmu_merge u_merge (
		.rot_val (rot_s2),
		.place   (place_s2),
		.result  (merged)
	);

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			res_s3 <= merged;
		end
	end

	assign res.valid  = v_s3;
	assign res.result = res_s3;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the bitfield move unit against its own prediction of every form:
// raw moves, extract and insert aliases, shifts and extends, both widths.
// A directed set covers the field extremes and the clamping and wrapping
// cases. Random operand sets then run under four idle and stall phases.
// ----------------------------------------------------------------------------
module testbench;
	import bfmu_pkg::*;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              wide;
		logic [DATA_W-1:0] src_value;
		logic [FA_W-1:0]   field_a;
		logic [FB_W-1:0]   field_b;
		logic [EB_W-1:0]   ext_bytes;
	} bf_op_t;

	typedef struct packed {
		bf_op_t            op;
		logic [DATA_W-1:0] value;
	} bf_expect_t;

	// predicts each transfer on the op side, checks each transfer on the res side
	class bfm_scoreboard;
		bf_expect_t  expected_results[$];
		int unsigned error_count = 0;

		function logic [63:0] ones_below(int unsigned n);
			return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
		endfunction

		// sign-extend the low n bits of v, keep w bits
		function logic [63:0] sign_fill(logic [63:0] v, int unsigned n, int unsigned w);
			logic [63:0] m;
			logic        s;
			m = ones_below(n);
			s = v[n-1];
			v = v & m;
			if (s)
				v = v | ~m;
			return v & ones_below(w);
		endfunction

		function logic [63:0] move_field(logic [63:0] src, int unsigned r, int unsigned s,
				int unsigned w, logic sgn);
			logic [63:0] v;
			int unsigned len, pos;
			if (s >= r) begin
				len = s - r + 1;
				v = (src >> r) & ones_below(len);
				if (sgn)
					v = sign_fill(v, len, w);
			end else begin
				pos = w - r;
				v = (src & ones_below(s + 1)) << pos;
				if (sgn)
					v = sign_fill(v, pos + s + 1, w);
			end
			return v & ones_below(w);
		endfunction

		// extract or insert-in-zero, width clamped to the register
		function logic [63:0] alias_field(logic [63:0] src, int unsigned lsb,
				int unsigned width, int unsigned w, logic insert, logic sgn);
			int unsigned r, s;
			if (width > w - lsb)
				width = w - lsb;
			if (width == 0)
				return '0;
			r = insert ? (w - lsb) % w : lsb;
			s = insert ? width - 1 : lsb + width - 1;
			return move_field(src, r, s, w, sgn);
		endfunction

		function logic [63:0] bitfield_result(bf_op_t it);
			int unsigned w, a, b, eb, s_raw, ebits;
			logic [63:0] src, res;
			w = it.wide ? REG_WIDTH : 32;
			src = it.src_value & ones_below(w);
			a = 32'(it.field_a) % w;
			b = 32'(it.field_b);
			eb = 32'(it.ext_bytes);
			s_raw = (b >= w) ? w - 1 : b;
			ebits = (eb == 1) ? 8 : ((eb == 2) ? 16 : 32);
			if (ebits > w)
				ebits = w;
			case (it.mode)
				MODE_UBFM:  res = move_field(src, a, s_raw, w, 1'b0);
				MODE_SBFM:  res = move_field(src, a, s_raw, w, 1'b1);
				MODE_UBFX:  res = alias_field(src, a, b, w, 1'b0, 1'b0);
				MODE_SBFX:  res = alias_field(src, a, b, w, 1'b0, 1'b1);
				MODE_UBFIZ: res = alias_field(src, a, b, w, 1'b1, 1'b0);
				MODE_SBFIZ: res = alias_field(src, a, b, w, 1'b1, 1'b1);
				MODE_LSL:   res = (src << a) & ones_below(w);
				MODE_LSR:   res = src >> a;
				MODE_ASR:   res = move_field(src, a, w - 1, w, 1'b1);
				MODE_UXT:   res = src & ones_below(ebits);
				MODE_SXT:   res = sign_fill(src, ebits, w);
				default:    res = '0;
			endcase
			return res & ones_below(w);
		endfunction

		function void note_op(bf_op_t it);
			bf_expect_t e;
			e.op = it;
			e.value = bitfield_result(it);
			expected_results.push_back(e);
		endfunction

		function void check_result(logic [DATA_W-1:0] actual);
			bf_expect_t e;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h, nothing expected", $time, actual);
				error_count++;
				return;
			end
			e = expected_results.pop_front();
			if (actual !== e.value) begin
				$display({"%0t: result mismatch mode %0d wide %0b src %h a %0d b %0d",
					" eb %0d: expected %h actual %h"},
					$time, e.op.mode, e.op.wide, e.op.src_value, e.op.field_a, e.op.field_b,
					e.op.ext_bytes, e.value, actual);
				error_count++;
			end
		endfunction

		function int unsigned outstanding();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bfmu_in_if  op_if ();
	bfmu_out_if res_if ();

	bitfield_move_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_if),
		.res    (res_if)
	);

	bfm_scoreboard sb = new();

	// chance in percent of an idle cycle on each side
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic bf_op_t make_op(logic [3:0] mode, logic wide, logic [63:0] src,
			logic [5:0] a, logic [6:0] b, logic [2:0] eb);
		bf_op_t it;
		it.mode = mode;
		it.wide = wide;
		it.src_value = src;
		it.field_a = a;
		it.field_b = b;
		it.ext_bytes = eb;
		return it;
	endfunction

	function automatic bf_op_t random_op();
		bf_op_t it;
		it.mode = ($urandom_range(99) < 90) ? 4'($urandom_range(MODE_SXT))
			: 4'($urandom_range(15, 11));
		it.wide = 1'($urandom_range(1));
		case ($urandom_range(9))
			0: it.src_value = '1;
			1: it.src_value = '0;
			2: it.src_value = 64'd1 << $urandom_range(63);
			3: it.src_value = {$urandom, $urandom} | 64'h8000_0000_8000_0000;
			default: it.src_value = {$urandom, $urandom};
		endcase
		it.field_a = 6'($urandom_range(63));
		it.field_b = ($urandom_range(99) < 85) ? 7'($urandom_range(64)) : 7'($urandom_range(127));
		case ($urandom_range(3))
			0: it.ext_bytes = 3'($urandom_range(7));
			1: it.ext_bytes = 3'd1;
			2: it.ext_bytes = 3'd2;
			default: it.ext_bytes = 3'd4;
		endcase
		return it;
	endfunction

	// present one operand set and hold it until the transfer
	task automatic send_op(bf_op_t it);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			op_if.valid <= 1'b0;
			@(posedge clk);
		end
		op_if.valid     <= 1'b1;
		op_if.mode      <= it.mode;
		op_if.wide      <= it.wide;
		op_if.src_value <= it.src_value;
		op_if.field_a   <= it.field_a;
		op_if.field_b   <= it.field_b;
		op_if.ext_bytes <= it.ext_bytes;
		do
			@(posedge clk);
		while (!op_if.ready);
		sb.note_op(it);
	endtask

	// result side: check each transfer, then pick the next ready value
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_if.valid && res_if.ready)
				sb.check_result(res_if.result);
			res_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		bf_op_t      directed[$];
		int unsigned phase_idle[4];
		int unsigned phase_stall[4];
		op_if.valid     <= 1'b0;
		op_if.mode      <= '0;
		op_if.wide      <= 1'b0;
		op_if.src_value <= '0;
		op_if.field_a   <= '0;
		op_if.field_b   <= '0;
		op_if.ext_bytes <= '0;
		arst_n          <= 1'b0;
		phase_idle  = '{0, 84, 0, 38};
		phase_stall = '{0, 0, 84, 38};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, wrapped rotate, sign at the top, saturated imms
		directed.push_back(make_op(MODE_UBFM, 1'b1, '1, 6'd0, 7'd63, 3'd0));
		directed.push_back(make_op(MODE_UBFM, 1'b1, 64'h0123_4567_89ab_cdef, 6'd60, 7'd3, 3'd0));
		directed.push_back(make_op(MODE_SBFM, 1'b1, 64'h8000_0000_0000_0000, 6'd63, 7'd63, 3'd7));
		directed.push_back(make_op(MODE_SBFM, 1'b0, '1, 6'd4, 7'd2, 3'd0));
		directed.push_back(make_op(MODE_UBFM, 1'b0, 64'hffff_ffff_8765_4321, 6'd40, 7'd127, 3'd0));
		directed.push_back(make_op(MODE_SBFM, 1'b1, 64'h7fff_ffff_ffff_ffff, 6'd1, 7'd64, 3'd0));
		// extract and insert with clamped and zero widths
		directed.push_back(make_op(MODE_UBFX, 1'b1, '1, 6'd60, 7'd10, 3'd0));
		directed.push_back(make_op(MODE_SBFX, 1'b1, 64'h0000_0000_0000_8000, 6'd8, 7'd8, 3'd0));
		directed.push_back(make_op(MODE_UBFX, 1'b0, '1, 6'd5, 7'd0, 3'd0));
		directed.push_back(make_op(MODE_UBFIZ, 1'b1, '1, 6'd0, 7'd64, 3'd0));
		directed.push_back(make_op(MODE_SBFIZ, 1'b0, 64'h1, 6'd31, 7'd1, 3'd0));
		directed.push_back(make_op(MODE_SBFIZ, 1'b1, 64'h5a5a_5a5a_5a5a_5a5a, 6'd63, 7'd127, 3'd0));
		// shifts at both ends, wrapped in the narrow width
		directed.push_back(make_op(MODE_LSL, 1'b1, '1, 6'd63, 7'd0, 3'd0));
		directed.push_back(make_op(MODE_LSL, 1'b0, 64'hffff_ffff_0000_00ff, 6'd40, 7'd0, 3'd0));
		directed.push_back(make_op(MODE_LSR, 1'b0, '1, 6'd31, 7'd0, 3'd0));
		directed.push_back(make_op(MODE_LSR, 1'b1, 64'h8000_0000_0000_0001, 6'd0, 7'd0, 3'd0));
		directed.push_back(make_op(MODE_ASR, 1'b1, 64'h8000_0000_0000_0000, 6'd63, 7'd0, 3'd0));
		directed.push_back(make_op(MODE_ASR, 1'b0, 64'h0000_0000_8000_0000, 6'd63, 7'd0, 3'd0));
		// extends by each byte count, the other counts falling back to four bytes
		directed.push_back(make_op(MODE_UXT, 1'b1, '1, 6'd0, 7'd0, 3'd1));
		directed.push_back(make_op(MODE_UXT, 1'b0, '1, 6'd0, 7'd0, 3'd2));
		directed.push_back(make_op(MODE_SXT, 1'b1, 64'h0000_0000_0000_0080, 6'd0, 7'd0, 3'd1));
		directed.push_back(make_op(MODE_SXT, 1'b1, 64'h0000_0000_8000_8000, 6'd0, 7'd0, 3'd4));
		directed.push_back(make_op(MODE_SXT, 1'b0, 64'hffff_0000_0000_8000, 6'd0, 7'd0, 3'd0));
		directed.push_back(make_op(MODE_SXT, 1'b1, 64'h0000_0000_ffff_ffff, 6'd0, 7'd0, 3'd7));
		// unused mode codes
		directed.push_back(make_op(4'd11, 1'b1, '1, 6'd63, 7'd127, 3'd7));
		directed.push_back(make_op(4'd15, 1'b0, '1, 6'd63, 7'd127, 3'd7));
		foreach (directed[i])
			send_op(directed[i]);

		for (int p = 0; p < 4; p++) begin
			idle_pct  = phase_idle[p];
			stall_pct = phase_stall[p];
			repeat (363)
				send_op(random_op());
		end
		op_if.valid <= 1'b0;

		// drain, then let the unit settle before the final check
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.error_count == 0 && sb.outstanding() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
